@@ design/ecs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecs_pkg
// shared types, codes and constants of the eeprom control sequencer
// ----------------------------------------------------------------------------
package ecs_pkg;

	localparam int ADDR_W = 10;
	localparam int TIME_W = 16;
	localparam int CFG_W  = 16;

	// item kinds
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	// bus register indexes
	localparam logic [1:0] REG_CONTROL = 2'd0;
	localparam logic [1:0] REG_DATA    = 2'd1;
	localparam logic [1:0] REG_ADDR_LO = 2'd2;
	localparam logic [1:0] REG_ADDR_HI = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_ATOMIC_TIME = 2'd0;
	localparam logic [1:0] CFG_SPLIT_TIME  = 2'd1;
	localparam logic [1:0] CFG_WINDOW      = 2'd2;
	localparam logic [1:0] CFG_READ_HALT   = 2'd3;

	// programming modes, control bits 5:4
	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_ERASE = 2'd1;
	localparam logic [1:0] MODE_AND   = 2'd2;
	localparam logic [1:0] MODE_NONE  = 2'd3;

	// control bit positions
	localparam int CTRL_READ_BIT = 0;
	localparam int CTRL_PROG_BIT = 1;
	localparam int CTRL_EN_BIT   = 2;
	localparam int CTRL_MODE_LO  = 4;

	localparam logic [7:0]        ERASED_BYTE      = 8'hFF;
	localparam logic [TIME_W-1:0] ATOMIC_TIME_RST  = 16'd48000;
	localparam logic [TIME_W-1:0] SPLIT_TIME_RST   = 16'd25000;
	localparam logic [7:0]        WINDOW_RST       = 8'd4;
	localparam logic [3:0]        READ_HALT_RST    = 4'd4;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_ENABLE = 2'd1,
		PH_READ   = 2'd2,
		PH_PROG   = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ST_CLEAR = 2'd0,
		ST_IDLE  = 2'd1,
		ST_EXEC  = 2'd2
	} ctl_state_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] reg_index;
		logic [7:0] write_data;
	} in_word_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [3:0] stall_cycles;
		logic       busy_res;
	} out_word_t;

	typedef struct packed {
		logic clear_step;
		logic capture;
		logic exec;
	} ctl_cmd_t;

	typedef struct packed {
		logic clear_last;
	} ctl_stat_t;

	// a timing value of zero behaves as one
	function automatic logic [TIME_W-1:0] at_least_one(input logic [TIME_W-1:0] v);
		return (v == '0) ? TIME_W'(1) : v;
	endfunction

endpackage

@@ design/eeprom_control_sequencer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eeprom_control_sequencer_top
// byte eeprom control sequencer: bus register accesses and ticks in, one
// result word out per accepted word
// ----------------------------------------------------------------------------
// Usage: a word (tick, register write or register read) is taken at a clock
// edge with start high and busy low. Each word is first captured, which
// latches it and reads the addressed byte from the byte store, and is then
// executed. The result word appears on result for exactly one cycle with done
// high, in the same cycle in which busy drops back low; it cannot be held
// off, and the next word may be started in that same cycle, not before. After
// reset the byte store is swept to the erased value, one byte per cycle; busy
// stays high during that pass. Configuration writes are taken at any edge with
// cfg_we high and should be issued while the block is idle.
// ----------------------------------------------------------------------------
module eeprom_control_sequencer_top import ecs_pkg::*; #(
	parameter int MEM_DEPTH = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	// command side
	input  logic             start,
	output logic             busy,
	input  in_word_t         item,
	// result side, one-cycle strobe
	output logic             done,
	output out_word_t        result,
	// configuration write port
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	ctl_cmd_t  cmd;
	ctl_stat_t stat;

	// controller: clearing pass, capture, execute
	ecs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// datapath: bus registers, timers, byte store and result register
	ecs_datapath #(
		.MEM_DEPTH (MEM_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result),
		.done      (done)
	);

endmodule

@@ design/ecs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecs_ctrl
// sequencing of the clearing pass, word capture and execution
// ----------------------------------------------------------------------------
module ecs_ctrl import ecs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  ctl_stat_t stat,
	output ctl_cmd_t  cmd,
	output logic      busy
);

	ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (stat.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	a_capture_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> cmd.exec)
		else $error("captured word not executed next cycle");

	a_exec_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> (!cmd.exec && !busy))
		else $error("word executed twice or block stuck busy");

endmodule

@@ design/ecs_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecs_datapath
// registers, byte store, timing countdown and result register
// ----------------------------------------------------------------------------
module ecs_datapath import ecs_pkg::*; #(
	parameter int MEM_DEPTH = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ctl_cmd_t         cmd,
	output ctl_stat_t        stat,
	input  in_word_t         item,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output out_word_t        result,
	output logic             done
);

	localparam int IDX_W = $clog2(MEM_DEPTH);
	localparam int MAX_Q = (2**ADDR_W - 1) / MEM_DEPTH;

	// configuration
	logic [TIME_W-1:0] atomic_time_q, split_time_q;
	logic [7:0]        window_q;
	logic [3:0]        read_halt_q;

	// architectural state
	phase_t            phase_q, phase_d;
	logic [TIME_W-1:0] cd_q, cd_d;
	logic [5:0]        ctrl_q, ctrl_d, ctrl_new;
	logic [7:0]        data_q, data_d;
	logic [ADDR_W-1:0] addr_q, addr_d;

	// captured word and store access
	in_word_t          item_q;
	logic [IDX_W-1:0]  idx_q, idx;
	logic [ADDR_W-1:0] idx_full;
	logic [7:0]        rdata_q;
	logic [IDX_W-1:0]  clr_q;
	logic [7:0]        mem_q [MEM_DEPTH];

	logic              prog_we;
	logic [7:0]        prog_wdata;
	logic [7:0]        rd;
	logic [3:0]        stall;
	logic [1:0]        mode;

	out_word_t         result_q;
	logic              done_q;

	// address modulo depth: quotient is at most MAX_Q, so parallel compares
	always_comb begin
		idx_full = addr_q;
		for (int k = 1; k <= MAX_Q; k++) begin
			if (addr_q >= ADDR_W'(k * MEM_DEPTH)) begin
				idx_full = addr_q - ADDR_W'(k * MEM_DEPTH);
			end
		end
		idx = idx_full[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atomic_time_q <= ATOMIC_TIME_RST;
			split_time_q  <= SPLIT_TIME_RST;
			window_q      <= WINDOW_RST;
			read_halt_q   <= READ_HALT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ATOMIC_TIME: atomic_time_q <= cfg_data;
				CFG_SPLIT_TIME:  split_time_q  <= cfg_data;
				CFG_WINDOW:      window_q      <= cfg_data[7:0];
				CFG_READ_HALT:   read_halt_q   <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	// one word's effect on the state
	always_comb begin
		phase_d    = phase_q;
		cd_d       = cd_q;
		ctrl_d     = ctrl_q;
		data_d     = data_q;
		addr_d     = addr_q;
		rd         = '0;
		stall      = '0;
		prog_we    = 1'b0;
		prog_wdata = ERASED_BYTE;
		ctrl_new   = ctrl_q | item_q.write_data[5:0];
		mode       = ctrl_new[CTRL_MODE_LO +: 2];
		case (item_q.kind)
			KIND_TICK: begin
				if (cd_q != '0) begin
					cd_d = cd_q - TIME_W'(1);
					if (cd_q == TIME_W'(1)) begin
						if (phase_q == PH_PROG) begin
							ctrl_d[CTRL_PROG_BIT] = 1'b0;
						end else if (phase_q == PH_ENABLE) begin
							ctrl_d[CTRL_EN_BIT] = 1'b0;
						end
						phase_d = PH_IDLE;
					end
				end
			end
			KIND_WRITE: begin
				case (item_q.reg_index)
					REG_CONTROL: begin
						ctrl_d = ctrl_new;
						if (phase_q == PH_IDLE) begin
							if (item_q.write_data[CTRL_READ_BIT]) begin
								phase_d = PH_READ;
								cd_d    = at_least_one(TIME_W'(read_halt_q));
								stall   = cd_d[3:0];
								data_d  = rdata_q;
							end else if (item_q.write_data[CTRL_EN_BIT]) begin
								phase_d = PH_ENABLE;
								cd_d    = at_least_one(TIME_W'(window_q));
							end
						end else if (phase_q == PH_ENABLE &&
								item_q.write_data[CTRL_PROG_BIT]) begin
							phase_d = PH_PROG;
							case (mode)
								MODE_WRITE: begin
									prog_we    = 1'b1;
									prog_wdata = data_q;
									cd_d       = at_least_one(atomic_time_q);
								end
								MODE_ERASE: begin
									prog_we    = 1'b1;
									prog_wdata = ERASED_BYTE;
									cd_d       = at_least_one(split_time_q);
								end
								MODE_AND: begin
									prog_we    = 1'b1;
									prog_wdata = rdata_q & data_q;
									cd_d       = at_least_one(split_time_q);
								end
								MODE_NONE: begin
									// window time carries over
								end
								default: begin
								end
							endcase
						end
					end
					REG_DATA:    data_d = item_q.write_data;
					REG_ADDR_LO: addr_d = {addr_q[ADDR_W-1:8], item_q.write_data};
					REG_ADDR_HI: addr_d = {item_q.write_data[1:0], addr_q[7:0]};
					default: begin
					end
				endcase
			end
			KIND_READ: begin
				case (item_q.reg_index)
					REG_CONTROL: rd = {2'b00, ctrl_q};
					REG_DATA:    rd = data_q;
					REG_ADDR_LO: rd = addr_q[7:0];
					REG_ADDR_HI: rd = {6'b000000, addr_q[ADDR_W-1:8]};
					default:     rd = '0;
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cd_q    <= '0;
			ctrl_q  <= '0;
			data_q  <= '0;
			addr_q  <= '0;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.exec;
			if (cmd.clear_step) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			if (cmd.exec) begin
				phase_q <= phase_d;
				cd_q    <= cd_d;
				ctrl_q  <= ctrl_d;
				data_q  <= data_d;
				addr_q  <= addr_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
			idx_q  <= idx;
		end
		if (cmd.exec) begin
			result_q.read_data    <= rd;
			result_q.stall_cycles <= stall;
			result_q.busy_res     <= (phase_d != PH_IDLE);
		end
	end

	// byte store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.clear_step) begin
			mem_q[clr_q] <= ERASED_BYTE;
		end else if (cmd.exec && prog_we) begin
			mem_q[idx_q] <= prog_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rdata_q <= mem_q[idx];
		end
	end

	assign stat.clear_last = (clr_q == IDX_W'(MEM_DEPTH - 1));
	assign result          = result_q;
	assign done            = done_q;

	a_idle_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) == (cd_q == '0))
		else $error("countdown out of step with phase");

	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(cmd.exec))
		else $error("result strobe without execution");

	a_busy_matches: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (result_q.busy_res == (phase_q != PH_IDLE)))
		else $error("reported busy differs from phase");

endmodule

@@ dv/eeprom_control_sequencer_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eeprom_control_sequencer_top_tb
// self-checking bench for the byte eeprom control sequencer: a short table of
// directed words, then random program / read / noise runs under several
// timing settings, every result word checked against its table entry or a cycle-free model
// ----------------------------------------------------------------------------
module eeprom_control_sequencer_top_tb;
	import ecs_pkg::*;

	localparam int MEM_DEPTH   = 1024;
	localparam int QUIET_LIMIT = 5000;   // longer than the clearing pass
	localparam int TICK_GUARD  = 300;    // longest countdown stepped out here
	localparam int REPORT_MAX  = 10;

	// kind code the block must ignore
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	// masks on control bytes: control bits only ever accumulate, so the mode
	// bits are opened in steps, write mode first, then and mode, then any
	// (erase and and are exclusive under one reset, so erase is left out)
	localparam logic [7:0] CTRL_KEEP_WRITE = 8'hCF;
	localparam logic [7:0] CTRL_KEEP_AND   = 8'hEF;
	localparam logic [7:0] CTRL_KEEP_ALL   = 8'hFF;

	localparam logic [7:0] READ_STROBE = 8'd1 << CTRL_READ_BIT;
	localparam logic [7:0] PROG_STROBE = 8'd1 << CTRL_PROG_BIT;
	localparam logic [7:0] EN_STROBE   = 8'd1 << CTRL_EN_BIT;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             start;
	logic             busy;
	in_word_t         item;
	logic             done;
	out_word_t        result;
	logic             cfg_we;
	logic [1:0]       cfg_index;
	logic [CFG_W-1:0] cfg_data;

	eeprom_control_sequencer_top #(
		.MEM_DEPTH(MEM_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// sequencer state as the bench sees it
	// ------------------------------------------------------------------
	phase_t      seq_phase;
	logic [15:0] seq_count;
	logic [5:0]  ctrl_bits;
	logic [7:0]  data_byte;
	logic [9:0]  addr_bits;
	logic [7:0]  mem_bytes [MEM_DEPTH];

	// timing registers as last written
	logic [15:0] t_atomic;
	logic [15:0] t_split;
	logic [7:0]  t_window;
	logic [3:0]  t_halt;

	// result words still owed by the block, oldest first
	out_word_t   due_results [$];

	int          fail_count;
	int          words_sent;
	int          gap_pct;
	bit          gaps_on;
	int          quiet_cycles;

	typedef struct {
		in_word_t  w;
		bit        typed;
		out_word_t res;
	} dir_row_t;

	dir_row_t    dir_rows [$];

	// ------------------------------------------------------------------
	// one word through the sequencer, returns the result word it causes
	// ------------------------------------------------------------------
	function automatic out_word_t sequencer_word(input in_word_t w);
		out_word_t   r;
		int unsigned idx;
		r = '0;
		idx = addr_bits % MEM_DEPTH;
		case (w.kind)
			KIND_TICK: begin
				if (seq_count != 0) begin
					seq_count = seq_count - 16'd1;
					// countdown ran out: window expiry drops enable,
					// finished program drops the program strobe
					if (seq_count == 0) begin
						if (seq_phase == PH_PROG)
							ctrl_bits[CTRL_PROG_BIT] = 1'b0;
						else if (seq_phase == PH_ENABLE)
							ctrl_bits[CTRL_EN_BIT] = 1'b0;
						seq_phase = PH_IDLE;
					end
				end
			end
			KIND_WRITE: begin
				case (w.reg_index)
					REG_CONTROL: begin
						ctrl_bits = ctrl_bits | w.write_data[5:0];
						if (seq_phase == PH_IDLE) begin
							// read strobe wins over enable when both are set
							if (w.write_data[CTRL_READ_BIT]) begin
								seq_phase = PH_READ;
								seq_count = (t_halt == 0) ? 16'd1 : {12'd0, t_halt};
								r.stall_cycles = seq_count[3:0];
								data_byte = mem_bytes[idx];
							end else if (w.write_data[CTRL_EN_BIT]) begin
								seq_phase = PH_ENABLE;
								seq_count = (t_window == 0) ? 16'd1 : {8'd0, t_window};
							end
						end else if (seq_phase == PH_ENABLE && w.write_data[CTRL_PROG_BIT]) begin
							seq_phase = PH_PROG;
							case (ctrl_bits[CTRL_MODE_LO +: 2])
								MODE_WRITE: begin
									mem_bytes[idx] = data_byte;
									seq_count = (t_atomic == 0) ? 16'd1 : t_atomic;
								end
								MODE_ERASE: begin
									mem_bytes[idx] = ERASED_BYTE;
									seq_count = (t_split == 0) ? 16'd1 : t_split;
								end
								MODE_AND: begin
									mem_bytes[idx] = mem_bytes[idx] & data_byte;
									seq_count = (t_split == 0) ? 16'd1 : t_split;
								end
								default: ;  // no byte touched, window time keeps running
							endcase
						end
					end
					REG_DATA:    data_byte = w.write_data;
					REG_ADDR_LO: addr_bits[7:0] = w.write_data;
					default:     addr_bits[9:8] = w.write_data[1:0];
				endcase
			end
			KIND_READ: begin
				case (w.reg_index)
					REG_CONTROL: r.read_data = {2'b00, ctrl_bits};
					REG_DATA:    r.read_data = data_byte;
					REG_ADDR_LO: r.read_data = addr_bits[7:0];
					default:     r.read_data = {6'd0, addr_bits[9:8]};
				endcase
			end
			default: ;  // unused kind changes nothing
		endcase
		r.busy_res = (seq_phase != PH_IDLE);
		return r;
	endfunction

	function automatic void add_row(input logic [1:0] k, input logic [1:0] ri,
		input logic [7:0] d, input bit typed, input logic [7:0] rd = 8'd0,
		input logic [3:0] st = 4'd0, input logic b = 1'b0);
		dir_row_t row;
		row.w = in_word_t'{k, ri, d};
		row.typed = typed;
		row.res = out_word_t'{rd, st, b};
		dir_rows.push_back(row);
	endfunction

	function automatic void note_failure(input string msg);
		fail_count++;
		if (fail_count <= REPORT_MAX)
			$display("%0t: %s", $realtime, msg);
	endfunction

	// ------------------------------------------------------------------
	// driving: inputs move on the falling edge, acceptance seen on rising
	// ------------------------------------------------------------------
	task automatic send_word(input in_word_t w, input bit typed = 1'b0,
		input out_word_t typed_res = '0);
		out_word_t r;
		// random sender gap ahead of this word
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
			repeat ($urandom_range(1, 4)) @(negedge clk);
		start = 1'b1;
		item = w;
		do @(posedge clk); while (busy);
		r = sequencer_word(w);
		due_results.push_back(typed ? typed_res : r);
		if (w.kind != KIND_UNUSED) begin
			words_sent++;
			// change gap density now and then, leaving gap-free stretches
			if (gaps_on && words_sent % 40 == 0) begin
				case ($urandom_range(0, 2))
					0:       gap_pct = 0;
					1:       gap_pct = 20;
					default: gap_pct = 50;
				endcase
			end
		end
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic put(input logic [1:0] k, input logic [1:0] ri, input logic [7:0] d);
		send_word(in_word_t'{k, ri, d});
	endtask

	// wait out every owed word, then load all four timing registers
	task automatic set_timing(input logic [15:0] a, input logic [15:0] s,
		input logic [15:0] w, input logic [15:0] h);
		while (due_results.size() != 0) @(posedge clk);
		repeat (3) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = CFG_ATOMIC_TIME;
		cfg_data = a;
		@(negedge clk);
		cfg_index = CFG_SPLIT_TIME;
		cfg_data = s;
		@(negedge clk);
		cfg_index = CFG_WINDOW;
		cfg_data = w;
		@(negedge clk);
		cfg_index = CFG_READ_HALT;
		cfg_data = h;
		@(negedge clk);
		cfg_we = 1'b0;
		t_atomic = a;
		t_split = s;
		t_window = w[7:0];
		t_halt = h[3:0];
	endtask

	// half the time stay on a few low addresses so reads hit programmed bytes
	function automatic logic [7:0] pick_low();
		return $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
	endfunction

	// step ticks (with the odd register read) until the sequencer is idle
	task automatic tick_until_idle();
		int guard;
		guard = 0;
		while (seq_phase != PH_IDLE && guard < TICK_GUARD) begin
			if ($urandom_range(0, 5) == 0)
				put(KIND_READ, 2'($urandom_range(0, 3)), 8'($urandom));
			else
				put(KIND_TICK, 2'($urandom_range(0, 3)), 8'($urandom));
			guard++;
		end
	endtask

	// address / data set-up, enable window, program strobe, run out the delay
	task automatic program_run(input logic [7:0] keep);
		if ($urandom_range(0, 1))
			put(KIND_WRITE, REG_ADDR_LO, pick_low());
		if ($urandom_range(0, 3) == 0)
			put(KIND_WRITE, REG_ADDR_HI, 8'($urandom));
		put(KIND_WRITE, REG_DATA, 8'($urandom));
		tick_until_idle();
		put(KIND_WRITE, REG_CONTROL, (8'($urandom) | EN_STROBE) & ~READ_STROBE & keep);
		// some ticks and data writes inside the window, never letting it close
		while (seq_phase == PH_ENABLE && seq_count > 1 && $urandom_range(0, 2) == 0) begin
			if ($urandom_range(0, 1))
				put(KIND_TICK, 2'($urandom_range(0, 3)), 8'($urandom));
			else
				put(KIND_WRITE, REG_DATA, 8'($urandom));
		end
		// mostly strobe, sometimes let the window expire
		if ($urandom_range(0, 7) != 0)
			put(KIND_WRITE, REG_CONTROL, (8'($urandom) | PROG_STROBE) & keep);
		tick_until_idle();
		if ($urandom_range(0, 1))
			put(KIND_READ, REG_CONTROL, 8'($urandom));
	endtask

	// read strobe on a (often recently programmed) byte, then read data back
	task automatic read_run(input logic [7:0] keep);
		if ($urandom_range(0, 1))
			put(KIND_WRITE, REG_ADDR_LO, pick_low());
		if ($urandom_range(0, 3) == 0)
			put(KIND_WRITE, REG_ADDR_HI, 8'($urandom));
		tick_until_idle();
		put(KIND_WRITE, REG_CONTROL, (8'($urandom) | READ_STROBE) & keep);
		put(KIND_READ, REG_DATA, 8'($urandom));
		tick_until_idle();
	endtask

	task automatic run_segment(input int target, input logic [7:0] keep);
		logic [1:0] k;
		logic [1:0] ri;
		logic [7:0] d;
		while (words_sent < target) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: program_run(keep);
				6, 7:             read_run(keep);
				default: begin
					// stray word of any kind, unused kind included
					k = 2'($urandom_range(0, 3));
					ri = 2'($urandom_range(0, 3));
					d = 8'($urandom);
					if (k == KIND_WRITE && ri == REG_CONTROL)
						d = d & keep;
					put(k, ri, d);
				end
			endcase
		end
	endtask

	// ------------------------------------------------------------------
	// result checking: every strobed word against the oldest owed one
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && done) begin
			if (due_results.size() == 0) begin
				note_failure($sformatf("unexpected result word %h", result));
			end else begin
				want = due_results.pop_front();
				if (result.read_data !== want.read_data
					|| result.stall_cycles !== want.stall_cycles
					|| result.busy_res !== want.busy_res)
					note_failure($sformatf(
						"word mismatch exp/act: read_data %h/%h stall %0d/%0d busy %0d/%0d",
						want.read_data, result.read_data, want.stall_cycles,
						result.stall_cycles, want.busy_res, result.busy_res));
			end
		end
	end

	// watchdog on cycles without any accepted word in either direction
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $realtime, QUIET_LIMIT);
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_ATOMIC_TIME;
		cfg_data = '0;
		fail_count = 0;
		words_sent = 0;
		gap_pct = 0;
		gaps_on = 1'b0;
		quiet_cycles = 0;

		// reset state of the bench copy
		seq_phase = PH_IDLE;
		seq_count = '0;
		ctrl_bits = '0;
		data_byte = '0;
		addr_bits = '0;
		foreach (mem_bytes[i])
			mem_bytes[i] = ERASED_BYTE;
		t_atomic = ATOMIC_TIME_RST;
		t_split = SPLIT_TIME_RST;
		t_window = WINDOW_RST;
		t_halt = READ_HALT_RST;

		// directed table, reset timing (read halt 4, window 4)
		// registers read back zero after reset
		add_row(KIND_READ, REG_CONTROL, 8'hFF, 1'b1);
		add_row(KIND_READ, REG_DATA, 8'h00, 1'b1);
		add_row(KIND_READ, REG_ADDR_LO, 8'hFF, 1'b1);
		add_row(KIND_READ, REG_ADDR_HI, 8'h00, 1'b1);
		// unused kind and an idle tick do nothing
		add_row(KIND_UNUSED, REG_ADDR_HI, 8'hFF, 1'b1);
		add_row(KIND_TICK, REG_CONTROL, 8'h00, 1'b1);
		// top address, high byte keeps two bits only
		add_row(KIND_WRITE, REG_ADDR_LO, 8'hFF, 1'b1);
		add_row(KIND_WRITE, REG_ADDR_HI, 8'hFF, 1'b1);
		add_row(KIND_READ, REG_ADDR_HI, 8'h00, 1'b1, 8'h03);
		add_row(KIND_READ, REG_ADDR_LO, 8'h00, 1'b1, 8'hFF);
		add_row(KIND_WRITE, REG_DATA, 8'h00, 1'b0);
		// read strobe with upper bits set: stalls, erased byte lands in data
		add_row(KIND_WRITE, REG_CONTROL, 8'hC1, 1'b1, 8'h00, 4'd4, 1'b1);
		add_row(KIND_READ, REG_DATA, 8'h00, 1'b1, 8'hFF, 4'd0, 1'b1);
		repeat (4)
			add_row(KIND_TICK, REG_DATA, 8'h00, 1'b0);
		add_row(KIND_READ, REG_CONTROL, 8'h00, 1'b0);
		// program strobe outside the window starts nothing
		add_row(KIND_WRITE, REG_CONTROL, PROG_STROBE, 1'b0);
		// open the window, a read strobe inside it is ignored, let it expire
		add_row(KIND_WRITE, REG_CONTROL, EN_STROBE, 1'b0);
		add_row(KIND_WRITE, REG_CONTROL, READ_STROBE, 1'b0);
		repeat (4)
			add_row(KIND_TICK, REG_ADDR_LO, 8'h00, 1'b0);

		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i])
			send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].res);

		gaps_on = 1'b1;
		gap_pct = 20;

		// write mode under short random timing
		set_timing(16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)),
			16'($urandom_range(2, 8)), 16'($urandom_range(1, 6)));
		run_segment(400, CTRL_KEEP_WRITE);

		// lowest legal values
		set_timing(16'd1, 16'd1, 16'd1, 16'd1);
		run_segment(550, CTRL_KEEP_WRITE);

		// zero timing acts as one; and mode opens here
		set_timing(16'd0, 16'd0, 16'd0, 16'd0);
		run_segment(700, CTRL_KEEP_AND);

		// junk above the register widths must be dropped
		set_timing(16'($urandom_range(1, 20)), 16'($urandom_range(1, 20)),
			{8'($urandom), 8'($urandom_range(2, 10))},
			{12'($urandom), 4'($urandom_range(1, 8))});
		run_segment(1100, CTRL_KEEP_AND);

		// anything goes, no-change mode included
		set_timing(16'($urandom_range(1, 30)), 16'($urandom_range(1, 30)),
			16'($urandom_range(1, 20)), 16'($urandom_range(1, 15)));
		run_segment(1350, CTRL_KEEP_ALL);

		// top values, back to back with no sender gaps
		gaps_on = 1'b0;
		gap_pct = 0;
		set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		run_segment(1450, CTRL_KEEP_ALL);

		// drain, then let the clock run on so stray result words are caught
		while (due_results.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);

		if (fail_count == 0 && due_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ sim.f @@
design/ecs_pkg.sv
design/ecs_ctrl.sv
design/ecs_datapath.sv
design/eeprom_control_sequencer_top.sv
dv/eeprom_control_sequencer_top_tb.sv
